FILE: rtl/cdq_pkg.sv
// Shared types and request codes for the circular deque.
`default_nettype none

package cdq_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 7;
  localparam int REQ_W  = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [REQ_W-1:0]         req_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_QUERY      = 3'd4;

  // Reported for both ends while the deque holds nothing
  localparam word_t EMPTY_WORD = '1;

endpackage

`default_nettype wire

FILE: rtl/cdq_in_if.sv
// Request channel of the circular deque.
`default_nettype none

interface cdq_in_if import cdq_pkg::*;;
  logic  valid;
  logic  ready;
  req_t  req_type;
  word_t value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/cdq_out_if.sv
// Result channel of the circular deque.
`default_nettype none

interface cdq_out_if import cdq_pkg::*;;
  logic  valid;
  logic  ready;
  logic  ok;
  word_t front_value;
  word_t rear_value;
  logic  is_empty;
  logic  is_full;
  cnt_t  occupancy;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, output occupancy, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, input occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/cdq_ring_store.sv
// Ring store: one write port, one read port with registered read data.
`default_nettype none

module cdq_ring_store import cdq_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  word_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output word_t             rd_data
);

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/circular_deque_core.sv
// Bounded double-ended queue of signed 32-bit words over a ring store.
//
// Channels: in_req carries one request (req_type, value) per valid/ready
// handshake; out_rsp returns exactly one result per request, describing
// the deque after that request. cfg_we/cfg_wdata write the capacity; a
// write is dropped unless the deque is empty, 0 is stored as 1 and values
// above DEPTH are stored as DEPTH.
//
// Timing: pushes, refused pops, queries, unknown codes and pops that empty
// the deque produce their result in the output register in the cycle
// after acceptance and allow one request per cycle while the receiver takes
// results. A pop that leaves entries behind fetches the new end word from
// the registered read port of the ring store in ST_FILL, where no request is
// taken; the result is then registered in the output register.
//
// The output register is freed in the cycle it is taken, so a new request
// is accepted while a finished result is being handed over. While the
// receiver stalls, the result holds and no new request is taken.
// Reset empties the deque and sets capacity to 64 (or DEPTH if smaller).
`default_nettype none

module circular_deque_core import cdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  cdq_in_if.sink           in_req,
  cdq_out_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_LIM = (DEPTH < 127) ? DEPTH : 127;
  localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

  localparam cnt_t             CAP_LIM_C = CNT_W'(CAP_LIM);
  localparam cnt_t             CAP_RST_C = CNT_W'(CAP_RST);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

  typedef enum logic {ST_IDLE, ST_FILL} state_t;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - ptr_t'(1);
  endfunction

  state_t state_r, state_nxt;
  ptr_t   front_ptr_r, front_ptr_nxt;
  ptr_t   rear_ptr_r, rear_ptr_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   cap_r, cap_nxt;
  logic   fill_front_r, fill_front_nxt;
  word_t  front_val_r, front_val_nxt;
  word_t  rear_val_r, rear_val_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_ok_r, out_ok_nxt;
  word_t  out_front_r, out_front_nxt;
  word_t  out_rear_r, out_rear_nxt;
  logic   out_empty_r, out_empty_nxt;
  logic   out_full_r, out_full_nxt;
  cnt_t   out_occ_r, out_occ_nxt;

  logic   accept;
  logic   req_ok;
  logic   wr_en, rd_en;
  ptr_t   wr_addr, rd_addr;
  word_t  rd_data;

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt      = state_r;
    front_ptr_nxt  = front_ptr_r;
    rear_ptr_nxt   = rear_ptr_r;
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    fill_front_nxt = fill_front_r;
    front_val_nxt  = front_val_r;
    rear_val_nxt   = rear_val_r;
    out_valid_nxt  = out_valid_r;
    out_ok_nxt     = out_ok_r;
    out_front_nxt  = out_front_r;
    out_rear_nxt   = out_rear_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_occ_nxt    = out_occ_r;
    req_ok         = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = front_ptr_r;
    rd_addr        = front_ptr_r;

    if (cfg_we && (count_r == '0)) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_wdata > CAP_LIM_C) begin
        cap_nxt = CAP_LIM_C;
      end else begin
        cap_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      case (in_req.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count_r < cap_r) begin
            req_ok    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            wr_en     = 1'b1;
            if (count_r == '0) begin
              rear_ptr_nxt  = front_ptr_r;
              wr_addr       = front_ptr_r;
              front_val_nxt = in_req.value;
              rear_val_nxt  = in_req.value;
            end else if (in_req.req_type == REQ_PUSH_FRONT) begin
              front_ptr_nxt = ptr_dec(front_ptr_r);
              wr_addr       = ptr_dec(front_ptr_r);
              front_val_nxt = in_req.value;
            end else begin
              rear_ptr_nxt  = ptr_inc(rear_ptr_r);
              wr_addr       = ptr_inc(rear_ptr_r);
              rear_val_nxt  = in_req.value;
            end
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (count_r != '0) begin
            req_ok    = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              rear_ptr_nxt = front_ptr_r;
            end else if (in_req.req_type == REQ_POP_FRONT) begin
              // fetch the word that becomes the new front
              front_ptr_nxt  = ptr_inc(front_ptr_r);
              rd_en          = 1'b1;
              rd_addr        = ptr_inc(front_ptr_r);
              fill_front_nxt = 1'b1;
            end else begin
              rear_ptr_nxt   = ptr_dec(rear_ptr_r);
              rd_en          = 1'b1;
              rd_addr        = ptr_dec(rear_ptr_r);
              fill_front_nxt = 1'b0;
            end
          end
        end
        REQ_QUERY: begin
          req_ok = 1'b1;
        end
        default: begin
          req_ok = 1'b0;
        end
      endcase

      out_ok_nxt    = req_ok;
      out_occ_nxt   = count_nxt;
      out_empty_nxt = (count_nxt == '0);
      out_full_nxt  = (count_nxt == cap_r);
      out_front_nxt = (count_nxt == '0) ? EMPTY_WORD : front_val_nxt;
      out_rear_nxt  = (count_nxt == '0) ? EMPTY_WORD : rear_val_nxt;
      out_valid_nxt = !rd_en;
      state_nxt     = rd_en ? ST_FILL : ST_IDLE;
    end

    if (state_r == ST_FILL) begin
      // patch the held result with the fetched end word
      if (fill_front_r) begin
        front_val_nxt = rd_data;
        out_front_nxt = rd_data;
      end else begin
        rear_val_nxt  = rd_data;
        out_rear_nxt  = rd_data;
      end
      out_valid_nxt = 1'b1;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_ptr_r <= '0;
      rear_ptr_r  <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RST_C;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_ptr_r <= front_ptr_nxt;
      rear_ptr_r  <= rear_ptr_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_front_r <= fill_front_nxt;
    front_val_r  <= front_val_nxt;
    rear_val_r   <= rear_val_nxt;
    out_ok_r     <= out_ok_nxt;
    out_front_r  <= out_front_nxt;
    out_rear_r   <= out_rear_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  cdq_ring_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_req.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_ok_r;
  assign out_rsp.front_value = out_front_r;
  assign out_rsp.rear_value  = out_rear_r;
  assign out_rsp.is_empty    = out_empty_r;
  assign out_rsp.is_full     = out_full_r;
  assign out_rsp.occupancy   = out_occ_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the circular deque core, with a request-level deque predictor.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam int DEQ_DEPTH  = 64;
  localparam int PTR_W      = $clog2(DEQ_DEPTH);
  localparam int MAX_CYCLES = 400000;
  localparam int SETTLE     = 4;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic  ok;
    word_t front_value;
    word_t rear_value;
    logic  is_empty;
    logic  is_full;
    cnt_t  occupancy;
  } deque_rsp_t;

  typedef struct packed {
    req_t  req_type;
    word_t value;
    logic  wait_drain;
  } deque_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  cdq_in_if  in_req ();
  cdq_out_if out_rsp ();

  circular_deque_core #(.DEPTH(DEQ_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  word_t ring_mem [DEQ_DEPTH];
  ptr_t  m_front;
  ptr_t  m_rear;
  int    m_count;
  int    m_cap;

  deque_req_t req_q[$];
  deque_rsp_t rsp_q[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  req_fired;
  int  cycle_cnt;
  int  err_cnt;
  int  n_req;
  int  n_refused;
  int  n_full;
  int  last_cap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_set_capacity(input logic [CNT_W-1:0] v);
    int c;
    c = int'(v);
    // Drop the write unless the deque is empty
    if (m_count != 0) return;
    if (c < 1) c = 1;
    if (c > DEQ_DEPTH) c = DEQ_DEPTH;
    m_cap = c;
  endfunction

  function automatic deque_rsp_t model_step(input req_t rq, input word_t w);
    deque_rsp_t r;
    r = '0;
    case (rq)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (m_count < m_cap) begin
          if (m_count == 0) m_rear = m_front;
          else if (rq == REQ_PUSH_FRONT) m_front = m_front - ptr_t'(1);
          else m_rear = m_rear + ptr_t'(1);
          if (rq == REQ_PUSH_FRONT) ring_mem[m_front] = w;
          else ring_mem[m_rear] = w;
          m_count++;
          r.ok = 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (m_count != 0) begin
          if (m_count == 1) m_rear = m_front;
          else if (rq == REQ_POP_FRONT) m_front = m_front + ptr_t'(1);
          else m_rear = m_rear - ptr_t'(1);
          m_count--;
          r.ok = 1'b1;
        end
      end
      REQ_QUERY: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    if (m_count == 0) begin
      r.front_value = EMPTY_WORD;
      r.rear_value  = EMPTY_WORD;
    end else begin
      r.front_value = ring_mem[m_front];
      r.rear_value  = ring_mem[m_rear];
    end
    r.is_empty  = (m_count == 0);
    r.is_full   = (m_count == m_cap);
    r.occupancy = cnt_t'(m_count);
    return r;
  endfunction

  task automatic add_req(input req_t rq, input word_t w, input logic hold = 1'b0);
    deque_req_t it;
    it.req_type   = rq;
    it.value      = w;
    it.wait_drain = hold;
    req_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || rsp_q.size() != 0 || in_req.valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    model_set_capacity(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic empty_deque();
    int n;
    n = m_count;
    repeat (n) add_req(REQ_POP_FRONT, word_t'($urandom));
    wait_idle();
  endtask

  // Bursts of pushes and pops so that both full and empty are reached often
  task automatic queue_random(input int n_items);
    int   made;
    int   kind;
    int   blen;
    int   pick;
    bit   first;
    req_t rq;
    made  = 0;
    first = 1'b1;
    while (made < n_items) begin
      if (first) begin
        kind = 0;
        blen = m_cap + 2;
      end else begin
        kind = $urandom_range(0, 99);
        blen = $urandom_range(1, m_cap + 4);
      end
      first = 1'b0;
      repeat (blen) begin
        pick = $urandom_range(0, 99);
        if (kind < 45) begin
          if (pick < 90) rq = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
          else if (pick < 96) rq = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
          else if (pick < 98) rq = REQ_QUERY;
          else rq = req_t'($urandom_range(5, 7));
        end else if (kind < 85) begin
          if (pick < 88) rq = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
          else if (pick < 96) rq = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
          else if (pick < 98) rq = REQ_QUERY;
          else rq = req_t'($urandom_range(5, 7));
        end else begin
          rq = req_t'($urandom_range(0, 7));
        end
        add_req(rq, word_t'($urandom), ($urandom_range(0, 99) == 0));
        if (rq <= REQ_QUERY) made++;
      end
    end
    wait_idle();
  endtask

  // Request driver: hold a request until taken, idle at random otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (in_req.valid && !req_fired) begin
      // hold the pending request
    end else if (req_q.size() != 0 && !(req_q[0].wait_drain && rsp_q.size() != 0) &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_req.valid    <= 1'b1;
      in_req.req_type <= req_q[0].req_type;
      in_req.value    <= req_q[0].value;
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_rsp.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: check results, then predict for the request taken at this edge
  always @(posedge clk) begin : monitor
    deque_rsp_t want;
    deque_rsp_t got;
    req_fired = 1'b0;
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        got.ok          = out_rsp.ok;
        got.front_value = out_rsp.front_value;
        got.rear_value  = out_rsp.rear_value;
        got.is_empty    = out_rsp.is_empty;
        got.is_full     = out_rsp.is_full;
        got.occupancy   = out_rsp.occupancy;
        if (rsp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: result with no request outstanding at cycle %0d", cycle_cnt);
        end else begin
          want = rsp_q.pop_front();
          if (got.ok !== want.ok || got.front_value !== want.front_value ||
              got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
              got.is_full !== want.is_full || got.occupancy !== want.occupancy) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("ERROR: cycle %0d expected ok=%b front=%h rear=%h empty=%b full=%b cnt=%0d",
                       cycle_cnt, want.ok, want.front_value, want.rear_value,
                       want.is_empty, want.is_full, want.occupancy);
              $display("       actual   ok=%b front=%h rear=%h empty=%b full=%b cnt=%0d",
                       got.ok, got.front_value, got.rear_value,
                       got.is_empty, got.is_full, got.occupancy);
            end
          end
          if (want.is_full) n_full++;
        end
      end
      if (in_req.valid && in_req.ready) begin
        req_fired = 1'b1;
        want = model_step(in_req.req_type, in_req.value);
        if (!want.ok) n_refused++;
        rsp_q.push_back(want);
        void'(req_q.pop_front());
        n_req++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_req.valid    = 1'b0;
    in_req.req_type = REQ_QUERY;
    in_req.value    = '0;
    out_rsp.ready   = 1'b0;
    cycle_cnt       = 0;
    err_cnt         = 0;
    n_req           = 0;
    n_refused       = 0;
    n_full          = 0;
    m_front         = '0;
    m_rear          = '0;
    m_count         = 0;
    m_cap           = DEQ_DEPTH;
    send_idle_pct   = 8;
    recv_idle_pct   = 71;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: refusals on empty and full, front wrap, last-entry pops
    write_capacity(7'd3);
    add_req(REQ_QUERY, 32'd0);
    add_req(REQ_POP_FRONT, 32'd0);
    add_req(REQ_POP_BACK, 32'd0);
    add_req(req_t'(5), 32'h1234_5678);
    add_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(REQ_PUSH_FRONT, 32'h8000_0000);
    add_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    add_req(REQ_PUSH_BACK, 32'd0);
    add_req(REQ_PUSH_FRONT, 32'd1);
    add_req(REQ_QUERY, 32'hFFFF_FFFF);
    add_req(req_t'(6), 32'd0);
    add_req(REQ_POP_BACK, 32'd0);
    add_req(REQ_POP_FRONT, 32'd0);
    add_req(REQ_POP_FRONT, 32'd0);
    add_req(REQ_POP_BACK, 32'd0);
    add_req(REQ_PUSH_BACK, 32'h5A5A_5A5A);
    add_req(REQ_POP_BACK, 32'd0, 1'b1);
    add_req(REQ_PUSH_BACK, 32'd0);
    add_req(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    add_req(req_t'(7), 32'hFFFF_FFFF);
    add_req(REQ_POP_FRONT, 32'd0);
    add_req(REQ_QUERY, 32'd0);
    wait_idle();
    // One entry held: this write must be dropped
    write_capacity(7'd0);
    add_req(REQ_PUSH_BACK, 32'd2);
    add_req(REQ_PUSH_BACK, 32'd3);
    add_req(REQ_PUSH_BACK, 32'd4);
    wait_idle();

    empty_deque();
    write_capacity(7'd5);
    queue_random(150);

    send_idle_pct = 71;
    recv_idle_pct = 8;
    empty_deque();
    write_capacity(7'd127);
    queue_random(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    empty_deque();
    write_capacity(7'd0);
    queue_random(50);

    empty_deque();
    last_cap = $urandom_range(2, DEQ_DEPTH - 1);
    write_capacity(cnt_t'(last_cap));
    queue_random(60);

    if (rsp_q.size() != 0) err_cnt++;
    $display("Checked %0d requests (%0d refused) at capacities 3, 5, 64, 1 and %0d;",
             n_req, n_refused, m_cap);
    $display("the deque reported full on %0d results across three idling patterns.", n_full);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: circular_deque_core.f
rtl/cdq_pkg.sv
rtl/cdq_in_if.sv
rtl/cdq_out_if.sv
rtl/cdq_ring_store.sv
rtl/circular_deque_core.sv
tb/sv/tb_top.sv
